FILE: sv/pcfd_pkg.sv
// ----------------------------------------------------------------------------
// pcfd_pkg
// Types, register indexes and the control store shared by the filtered
// derivative PID core and its datapath.
// ----------------------------------------------------------------------------
package pcfd_pkg;

    localparam int unsigned GAIN_W  = 31;
    localparam int unsigned ALPHA_W = 17;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ACC_W   = 50;
    localparam int unsigned PC_W    = 4;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               limited;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [ALPHA_W-1:0] filter_alpha;
        logic [GAIN_W-1:0]  integrate_below;
        logic [GAIN_W-1:0]  integral_limit;
        logic signed [31:0] drive_max;
        logic signed [31:0] drive_min;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_FILTER_ALPHA    = 3'd3,
        REG_INTEGRATE_BELOW = 3'd4,
        REG_INTEGRAL_LIMIT  = 3'd5,
        REG_DRIVE_MAX       = 3'd6,
        REG_DRIVE_MIN       = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ERR       = 4'd1,
        OP_INTEG     = 4'd2,
        OP_FACC_LOAD = 4'd3,
        OP_FACC_ADD  = 4'd4,
        OP_FD_WRITE  = 4'd5,
        OP_DSUM_LOAD = 4'd6,
        OP_DSUM_ADD  = 4'd7,
        OP_OUT       = 4'd8,
        OP_CLEAR     = 4'd9
    } dp_op_t;

    typedef enum logic [2:0] {
        A_ALPHA   = 3'd0,
        A_ONE_M   = 3'd1,
        A_GAIN_P  = 3'd2,
        A_GAIN_I  = 3'd3,
        A_GAIN_D  = 3'd4
    } mul_a_t;

    typedef enum logic [1:0] {
        B_DIFF  = 2'd0,
        B_FDIFF = 2'd1,
        B_ERR   = 2'd2,
        B_INTEG = 2'd3
    } mul_b_t;

    typedef enum logic [1:0] {
        JMP_NONE  = 2'd0,
        JMP_CLEAR = 2'd1
    } jump_t;

    typedef struct packed {
        dp_op_t          op;
        logic            mul_en;
        mul_a_t          a_sel;
        mul_b_t          b_sel;
        jump_t           jump;
        logic [PC_W-1:0] target;
        logic            done;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] UC_START = 4'd0;
    localparam logic [PC_W-1:0] UC_CLEAR = 4'd10;

    function automatic ctrl_word_t uc_word(dp_op_t op, logic mul_en, mul_a_t a_sel,
                                           mul_b_t b_sel, logic done);
        ctrl_word_t w;
        w.op     = op;
        w.mul_en = mul_en;
        w.a_sel  = a_sel;
        w.b_sel  = b_sel;
        w.jump   = JMP_NONE;
        w.target = UC_START;
        w.done   = done;
        return w;
    endfunction

    // control store: one word per step
    function automatic ctrl_word_t ucode_rom(logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = uc_word(OP_NOP, 1'b0, A_ALPHA, B_DIFF, 1'b1);
        unique case (pc)
            4'd0: begin
                w = uc_word(OP_ERR, 1'b0, A_ALPHA, B_DIFF, 1'b0);
                w.jump   = JMP_CLEAR;
                w.target = UC_CLEAR;
            end
            4'd1:  w = uc_word(OP_INTEG,     1'b0, A_ALPHA,  B_DIFF,  1'b0);
            4'd2:  w = uc_word(OP_NOP,       1'b1, A_ALPHA,  B_DIFF,  1'b0);
            4'd3:  w = uc_word(OP_FACC_LOAD, 1'b1, A_ONE_M,  B_FDIFF, 1'b0);
            4'd4:  w = uc_word(OP_FACC_ADD,  1'b0, A_ALPHA,  B_DIFF,  1'b0);
            4'd5:  w = uc_word(OP_FD_WRITE,  1'b1, A_GAIN_P, B_ERR,   1'b0);
            4'd6:  w = uc_word(OP_DSUM_LOAD, 1'b1, A_GAIN_I, B_INTEG, 1'b0);
            4'd7:  w = uc_word(OP_DSUM_ADD,  1'b1, A_GAIN_D, B_FDIFF, 1'b0);
            4'd8:  w = uc_word(OP_DSUM_ADD,  1'b0, A_ALPHA,  B_DIFF,  1'b0);
            4'd9:  w = uc_word(OP_OUT,       1'b0, A_ALPHA,  B_DIFF,  1'b1);
            4'd10: w = uc_word(OP_CLEAR,     1'b0, A_ALPHA,  B_DIFF,  1'b1);
            default: w = uc_word(OP_NOP, 1'b0, A_ALPHA, B_DIFF, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(signed'(32'sh7FFFFFFF))) begin
            r = 32'sh7FFFFFFF;
        end else if (v < ACC_W'(signed'(32'sh80000000))) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/pcfd_datapath.sv
// ----------------------------------------------------------------------------
// pcfd_datapath
// Controller state, one shared 32x32 multiplier and the accumulators,
// driven one control word per cycle by the sequencer while step_en is high.
// ----------------------------------------------------------------------------
module pcfd_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  pcfd_pkg::ctrl_word_t  ctrl,
    input  pcfd_pkg::cfg_t        cfg,
    input  pcfd_pkg::in_item_t    item,
    output pcfd_pkg::out_item_t   result
);
    import pcfd_pkg::*;

    logic signed [31:0]      err_reg, diff_reg, integ_reg, last_err_reg, fdiff_reg;
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] facc_reg, dsum_reg;

    logic signed [32:0]      err_wide, diff_wide, integ_wide, lim_pos, lim_neg;
    logic signed [32:0]      err_abs;
    logic signed [31:0]      err_sat, diff_sat, integ_sum, integ_clamped, fd_sat;
    logic                    integ_gate;
    logic [ALPHA_W-1:0]      alpha_eff, alpha_rest;
    logic signed [31:0]      mul_a, mul_b;
    logic signed [63:0]      rnd_full;
    logic signed [ACC_W-1:0] rnd_term, prod_ext;
    logic signed [31:0]      drive_sat, drive_hi, drive_fin;

    // error and integrator
    always_comb begin
        err_wide   = 33'(item.setpoint) - 33'(item.measured);
        err_sat    = sat32(ACC_W'(err_wide));
        err_abs    = err_reg[31] ? -33'(err_reg) : 33'(err_reg);
        integ_gate = err_abs[31:0] < {1'b0, cfg.integrate_below};
        integ_wide = 33'(integ_reg) + 33'(err_reg);
        integ_sum  = integ_gate ? sat32(ACC_W'(integ_wide)) : integ_reg;
        lim_pos    = {2'b00, cfg.integral_limit};
        lim_neg    = -lim_pos;
        if (33'(integ_sum) > lim_pos) begin
            integ_clamped = lim_pos[31:0];
        end else if (33'(integ_sum) < lim_neg) begin
            integ_clamped = lim_neg[31:0];
        end else begin
            integ_clamped = integ_sum;
        end
        diff_wide = 33'(err_reg) - 33'(last_err_reg);
        diff_sat  = sat32(ACC_W'(diff_wide));
    end

    // multiplier operands
    always_comb begin
        alpha_eff  = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
        alpha_rest = ALPHA_ONE - alpha_eff;
        unique case (ctrl.a_sel)
            A_ALPHA:  mul_a = {15'd0, alpha_eff};
            A_ONE_M:  mul_a = {15'd0, alpha_rest};
            A_GAIN_P: mul_a = {1'b0, cfg.gain_p};
            A_GAIN_I: mul_a = {1'b0, cfg.gain_i};
            A_GAIN_D: mul_a = {1'b0, cfg.gain_d};
            default:  mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            B_DIFF:  mul_b = diff_reg;
            B_FDIFF: mul_b = fdiff_reg;
            B_ERR:   mul_b = err_reg;
            B_INTEG: mul_b = integ_reg;
            default: mul_b = '0;
        endcase
    end

    // product rounding and filter result
    always_comb begin
        prod_ext = prod_reg[ACC_W-1:0];
        rnd_full = prod_reg + 64'sd32768;
        rnd_term = {{2{rnd_full[63]}}, rnd_full[63:16]};
        fd_sat   = sat32({{16{facc_reg[ACC_W-1]}}, facc_reg[ACC_W-1:16]});
    end

    // drive limiting
    always_comb begin
        drive_sat = sat32(dsum_reg);
        drive_hi  = (drive_sat > cfg.drive_max) ? cfg.drive_max : drive_sat;
        drive_fin = (drive_hi < cfg.drive_min) ? cfg.drive_min : drive_hi;
        if (ctrl.op == OP_CLEAR) begin
            result.drive   = '0;
            result.limited = 1'b0;
        end else begin
            result.drive   = drive_fin;
            result.limited = ACC_W'(drive_fin) != dsum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg      <= '0;
            diff_reg     <= '0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            fdiff_reg    <= '0;
            facc_reg     <= '0;
            dsum_reg     <= '0;
            prod_reg     <= '0;
        end else if (step_en) begin
            if (ctrl.mul_en) begin
                prod_reg <= mul_a * mul_b;
            end
            unique case (ctrl.op)
                OP_ERR: begin
                    err_reg <= err_sat;
                end
                OP_INTEG: begin
                    integ_reg    <= integ_clamped;
                    diff_reg     <= diff_sat;
                    last_err_reg <= err_reg;
                end
                OP_FACC_LOAD: begin
                    facc_reg <= prod_ext + ACC_W'(32768);
                end
                OP_FACC_ADD: begin
                    facc_reg <= facc_reg + prod_ext;
                end
                OP_FD_WRITE: begin
                    fdiff_reg <= fd_sat;
                end
                OP_DSUM_LOAD: begin
                    dsum_reg <= rnd_term;
                end
                OP_DSUM_ADD: begin
                    dsum_reg <= dsum_reg + rnd_term;
                end
                OP_CLEAR: begin
                    integ_reg    <= '0;
                    last_err_reg <= '0;
                    fdiff_reg    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: sv/pid_controller_filtered_derivative_core.sv
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative_core
// PID controller with gated integration, filtered derivative and a limited
// drive, sequenced by a small control store.
// ----------------------------------------------------------------------------
// An update item runs a ten-step program after acceptance, whose last step
// writes its result to the output register; a clear item takes two steps. The
// input is taken again in the cycle after the result is written, so the core
// takes no new item until the last one is through. The single 32x32
// multiplier serves the filter and the three gain products in turn.
// A finished result waits in the output register while the next item runs.
// Configuration is a plain write port with no read-back.
module pid_controller_filtered_derivative_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pcfd_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pcfd_pkg::out_item_t  m_item
);
    import pcfd_pkg::*;

    cfg_t            cfg_reg;
    in_item_t        item_reg;
    logic            busy_reg;
    logic [PC_W-1:0] pc_reg;
    logic            m_valid_reg;
    out_item_t       m_item_reg;

    ctrl_word_t      ctrl;
    logic            out_free, step_en;
    out_item_t       result;

    assign ctrl     = ucode_rom(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    // the result step waits for a free output register
    assign step_en  = busy_reg && (!ctrl.done || out_free);
    assign s_ready  = !busy_reg;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p          <= '0;
            cfg_reg.gain_i          <= '0;
            cfg_reg.gain_d          <= '0;
            cfg_reg.filter_alpha    <= ALPHA_ONE;
            cfg_reg.integrate_below <= '0;
            cfg_reg.integral_limit  <= '0;
            cfg_reg.drive_max       <= 32'sh7FFFFFFF;
            cfg_reg.drive_min       <= 32'sh80000000;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_GAIN_P:          cfg_reg.gain_p          <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:          cfg_reg.gain_i          <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:          cfg_reg.gain_d          <= cfg_wdata[GAIN_W-1:0];
                REG_FILTER_ALPHA:    cfg_reg.filter_alpha    <= cfg_wdata[ALPHA_W-1:0];
                REG_INTEGRATE_BELOW: cfg_reg.integrate_below <= cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT:  cfg_reg.integral_limit  <= cfg_wdata[GAIN_W-1:0];
                REG_DRIVE_MAX:       cfg_reg.drive_max       <= cfg_wdata;
                REG_DRIVE_MIN:       cfg_reg.drive_min       <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= UC_START;
        end else if (!busy_reg) begin
            if (s_valid) begin
                busy_reg <= 1'b1;
                pc_reg   <= UC_START;
            end
        end else if (step_en) begin
            if (ctrl.jump == JMP_CLEAR && item_reg.cmd) begin
                pc_reg <= ctrl.target;
            end else if (ctrl.done) begin
                busy_reg <= 1'b0;
                pc_reg   <= UC_START;
            end else begin
                pc_reg <= pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en && ctrl.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && ctrl.done) begin
            m_item_reg <= result;
        end
    end

    pcfd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (result)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the filtered derivative PID core. A software model
// of the controller state predicts drive and limit flag for every accepted
// item; results are compared in order while both handshakes idle at random
// in most phases and the register settings change between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import pcfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    class drive_scoreboard;
        logic [GAIN_W-1:0]  kp, ki, kd, below, i_limit;
        logic [ALPHA_W-1:0] alpha;
        int                 dmax, dmin;
        int                 integ, prev_err, fdiff;
        out_item_t          expected_drive_q[$];
        int                 errors;

        function new();
            kp       = '0;
            ki       = '0;
            kd       = '0;
            below    = '0;
            i_limit  = '0;
            alpha    = ALPHA_ONE;
            dmax     = 32'sh7FFFFFFF;
            dmin     = 32'sh80000000;
            integ    = 0;
            prev_err = 0;
            fdiff    = 0;
            errors   = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_GAIN_P:          kp = val[GAIN_W-1:0];
                REG_GAIN_I:          ki = val[GAIN_W-1:0];
                REG_GAIN_D:          kd = val[GAIN_W-1:0];
                REG_FILTER_ALPHA:    alpha = val[ALPHA_W-1:0];
                REG_INTEGRATE_BELOW: below = val[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT:  i_limit = val[GAIN_W-1:0];
                REG_DRIVE_MAX:       dmax = val;
                REG_DRIVE_MIN:       dmin = val;
                default: ;
            endcase
        endfunction

        function int clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return int'(v);
        endfunction

        // gain times value, rounded to Q16.16 (arithmetic shift is a floor)
        function longint round_mul(logic [GAIN_W-1:0] g, int x);
            longint p;
            p = longint'(g) * longint'(x) + 64'sd32768;
            return p >>> 16;
        endfunction

        function out_item_t predict_drive(in_item_t it);
            out_item_t r;
            int        err, dif, drv;
            longint    mag, alf, acc, total;
            if (it.cmd) begin
                integ    = 0;
                prev_err = 0;
                fdiff    = 0;
                r.drive   = '0;
                r.limited = 1'b0;
                return r;
            end
            err = clip32(longint'(signed'(it.setpoint)) - longint'(signed'(it.measured)));
            mag = (err < 0) ? -longint'(err) : longint'(err);
            if (mag < longint'(below)) integ = clip32(longint'(integ) + longint'(err));
            if (integ > int'(i_limit)) integ = int'(i_limit);
            if (integ < -int'(i_limit)) integ = -int'(i_limit);
            dif = clip32(longint'(err) - longint'(prev_err));
            alf = (alpha > ALPHA_ONE) ? 64'sd65536 : longint'(alpha);
            acc = alf * longint'(dif) + (64'sd65536 - alf) * longint'(fdiff) + 64'sd32768;
            fdiff    = clip32(acc >>> 16);
            prev_err = err;
            total = round_mul(kp, err) + round_mul(ki, integ) + round_mul(kd, fdiff);
            drv = clip32(total);
            if (drv > dmax) drv = dmax;
            if (drv < dmin) drv = dmin;
            r.drive   = drv;
            r.limited = (longint'(drv) != total);
            return r;
        endfunction

        function void note_input(in_item_t it);
            expected_drive_q.push_back(predict_drive(it));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_drive_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual drive %0d limited %0b",
                         $time, got.drive, got.limited);
                errors++;
                return;
            end
            want = expected_drive_q.pop_front();
            if (got.drive !== want.drive) begin
                $display("%0t: drive mismatch, expected %0d actual %0d",
                         $time, want.drive, got.drive);
                errors++;
            end
            if (got.limited !== want.limited) begin
                $display("%0t: limited mismatch, expected %0b actual %0b",
                         $time, want.limited, got.limited);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;

    drive_scoreboard sb = new();
    int              gap_pct;
    int              stall_pct;
    int              cycle_count;

    pid_controller_filtered_derivative_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    // result side back-pressure in bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 99) < stall_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // called at a falling edge; returns at a falling edge with valid possibly still high
    task automatic push_item(in_item_t it);
        s_item  = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        @(negedge aclk);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
    endtask

    task automatic send_op(logic cmd, logic [31:0] sp, logic [31:0] ms);
        in_item_t it;
        it.cmd      = cmd;
        it.setpoint = sp;
        it.measured = ms;
        push_item(it);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (sb.expected_drive_q.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic set_reg(reg_idx_t idx, logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic load_config(logic [31:0] g_p, logic [31:0] g_i, logic [31:0] g_d,
                               logic [31:0] alf, logic [31:0] blw, logic [31:0] lim,
                               logic [31:0] hi, logic [31:0] lo);
        set_reg(REG_GAIN_P, g_p);
        set_reg(REG_GAIN_I, g_i);
        set_reg(REG_GAIN_D, g_d);
        set_reg(REG_FILTER_ALPHA, alf);
        set_reg(REG_INTEGRATE_BELOW, blw);
        set_reg(REG_INTEGRAL_LIMIT, lim);
        set_reg(REG_DRIVE_MAX, hi);
        set_reg(REG_DRIVE_MIN, lo);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'h7FFFFFFF;
            5:       return $urandom & 32'h7FFFFFFF;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_alpha();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'h0001_0000;
            2:       return 32'h0001_FFFF;
            3:       return $urandom_range(0, 32'h0001_FFFF);
            default: return $urandom_range(0, 32'h0001_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_bound(int unsigned typical);
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'h7FFFFFFF;
            2:       return $urandom & 32'h7FFFFFFF;
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3:       return 32'hFFFFFFFF;
            default: return 32'h1;
        endcase
    endfunction

    function automatic logic [31:0] pick_drive_limit();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return ($urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned sel;
        logic [31:0] e;
        sel         = $urandom_range(0, 99);
        it.cmd      = (sel < 3);
        it.setpoint = $urandom;
        if (sel < 20) begin
            it.measured = $urandom;
        end else if (sel < 28) begin
            it.setpoint = pick_extreme();
            it.measured = pick_extreme();
        end else begin
            // small error around a random operating point, so the integral works
            e           = $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
            it.measured = it.setpoint - e;
        end
        return it;
    endfunction

    initial begin
        logic [31:0] hi, lo;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_GAIN_P;
        cfg_wdata = '0;
        gap_pct   = 20;
        stall_pct = 10;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: zero gains, full range limits
        send_op(1'b0, 32'h0001_0000, 32'h0);
        send_op(1'b0, 32'h7FFFFFFF, 32'h80000000);
        settle();

        // kp 1.0, ki 0.5, kd 0.25, alpha 0.5, gate 100.0, clamp 50.0, drive +-1000.0
        load_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_8000,
                    32'h0064_0000, 32'h0032_0000, 32'h03E8_0000, 32'hFC18_0000);
        send_op(1'b0, 32'h7FFFFFFF, 32'h80000000);   // error saturates high
        send_op(1'b0, 32'h80000000, 32'h7FFFFFFF);   // error saturates low
        send_op(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_op(1'b0, 32'h80000000, 32'h80000000);
        send_op(1'b0, 32'h0064_0000, 32'h0);         // error on the gate, not integrated
        send_op(1'b0, 32'h0063_FFFF, 32'h0);         // just inside the gate
        repeat (3) send_op(1'b0, 32'h0028_0000, 32'h0);  // integral runs into the clamp
        repeat (3) send_op(1'b0, 32'h0, 32'h0028_0000);
        send_op(1'b1, 32'h1234_5678, 32'h0BAD_F00D);   // clear
        send_op(1'b0, 32'h0001_0000, 32'h0);
        send_op(1'b0, 32'h0500_0000, 32'h0);         // above the upper drive limit
        send_op(1'b0, 32'h0, 32'h0500_0000);         // below the lower drive limit
        settle();

        // alpha above one, integral clamp at zero, lower limit above upper
        load_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_FFFF,
                    32'h0064_0000, 32'h0, 32'hFFF6_0000, 32'h000A_0000);
        send_op(1'b0, 32'h0002_0000, 32'h0);
        send_op(1'b0, 32'hFFFF_0000, 32'h0);
        send_op(1'b0, 32'h0000_8000, 32'h0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 6 || ph == 3) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 40);
                stall_pct = $urandom_range(5, 25);
            end
            if (ph == 0) begin
                load_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0001_FFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
            end else if (ph == 1) begin
                load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                            32'h80000000, 32'h7FFFFFFF);
            end else begin
                hi = pick_drive_limit();
                lo = pick_drive_limit();
                // mostly a sane window, sometimes left inverted
                if ($signed(lo) > $signed(hi) && $urandom_range(0, 3) != 0) begin
                    {hi, lo} = {lo, hi};
                end
                load_config(pick_gain(), pick_gain(), pick_gain(), pick_alpha(),
                            pick_bound(32'h0008_0000), pick_bound(32'h0020_0000), hi, lo);
            end
            repeat (160) push_item(rand_item());
            settle();
        end

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
